>>> design/mcmf_pkg.sv
// shared types and constants of the min-cost max-flow engine
package mcmf_pkg;

  localparam int NODES  = 128;
  localparam int EDGES  = 8192;
  localparam int NODE_W = 7;
  localparam int EIDX_W = 13;
  localparam int LINK_W = 14;

  // link value meaning "no entry", one past the last entry
  localparam logic [LINK_W-1:0] NO_EDGE = LINK_W'(EDGES);
  localparam logic [LINK_W-1:0] EDGE_ROOM = LINK_W'(EDGES - 2);
  localparam logic [NODE_W-1:0] HOP_LAST = NODE_W'(NODES - 1);

  localparam logic signed [47:0] COST_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COST_MIN = 48'sh8000_0000_0000;
  localparam logic [19:0] FLOW_MAX = 20'hF_FFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_SOURCE   = 2'd0;
  localparam logic [1:0] CFG_SINK     = 2'd1;
  localparam logic [1:0] CFG_REQUIRED = 2'd2;

  typedef struct packed {
    logic [6:0]         from_node;
    logic [6:0]         to_node;
    logic [15:0]        capacity;
    logic signed [15:0] edge_cost;
    logic               last_edge;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] total_cost;
    logic [19:0]        total_flow;
    logic               feasible;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  source_node;
    logic [6:0]  sink_node;
    logic [19:0] required_flow;
  } cfg_t;

  typedef struct packed {
    logic [6:0]         head;
    logic [6:0]         tail;
    logic [15:0]        res;
    logic signed [16:0] cost;
    logic [13:0]        link;
  } edge_t;

  typedef struct packed {
    logic signed [31:0] dval;
    logic [13:0]        arr;
    logic [6:0]         hop;
  } node_t;

endpackage

>>> design/mcmf_engine.sv
// edge store, search memories and the sequencer of the flow solver
module mcmf_engine import mcmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  input  in_word_t  in_data_i,
  output logic      in_ready_o,
  input  logic      out_free_i,
  output logic      res_valid_o,
  output out_word_t res_o
);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_LD_F   = 17'h00002,
    ST_LD_R   = 17'h00004,
    ST_INIT   = 17'h00008,
    ST_POP    = 17'h00010,
    ST_POP_RD = 17'h00020,
    ST_LIST   = 17'h00040,
    ST_EDGE   = 17'h00080,
    ST_RELAX  = 17'h00100,
    ST_WALK_A = 17'h00200,
    ST_WALK_B = 17'h00400,
    ST_WALK_C = 17'h00800,
    ST_WALK_D = 17'h01000,
    ST_WALK_E = 17'h02000,
    ST_ACC1   = 17'h04000,
    ST_ACC2   = 17'h08000,
    ST_DONE   = 17'h10000
  } state_e;

  // memories
  edge_t             edge_mem [EDGES];
  node_t             node_mem [NODES];
  logic [LINK_W-1:0] ls_mem   [NODES];
  logic [NODE_W-1:0] q_mem    [NODES];

  edge_t             edge_rd_q;
  node_t             node_rd_q;
  logic [LINK_W-1:0] ls_rd_q;
  logic [NODE_W-1:0] q_rd_q;

  logic              edge_we, edge_re;
  logic [EIDX_W-1:0] edge_wa, edge_ra;
  edge_t             edge_wd;
  logic              node_we, node_re;
  logic [NODE_W-1:0] node_wa, node_ra;
  node_t             node_wd;
  logic              ls_we, ls_re;
  logic [NODE_W-1:0] ls_wa, ls_ra;
  logic [LINK_W-1:0] ls_wd;
  logic              q_we, q_re;
  logic [NODE_W-1:0] q_wa, q_ra, q_wd;

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_rd_q <= edge_mem[edge_ra];
  end
  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_rd_q <= node_mem[node_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[ls_wa] <= ls_wd;
    if (ls_re) ls_rd_q <= ls_mem[ls_ra];
  end
  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_q <= q_mem[q_ra];
  end

  // registers
  state_e             state_q, state_d;
  logic [LINK_W-1:0]  edge_total_q, edge_total_d;
  logic [NODES-1:0]   ls_vld_q, ls_vld_d;
  logic [NODES-1:0]   reached_q, reached_d;
  logic [NODES-1:0]   queued_q, queued_d;
  logic [NODE_W-1:0]  head_q, head_d;
  logic [NODE_W:0]    count_q, count_d;
  logic               pass_q, pass_d;
  logic               neck_none_q, neck_none_d;
  logic [NODE_W:0]    steps_q, steps_d;
  in_word_t           item_q, item_d;
  logic [NODE_W-1:0]  x_q, x_d;
  logic signed [31:0] dist_x_q, dist_x_d;
  logic [NODE_W-1:0]  hop_x_q, hop_x_d;
  logic [LINK_W-1:0]  k_q, k_d;
  logic [NODE_W-1:0]  y_q, y_d;
  logic signed [31:0] nd_q, nd_d;
  logic [LINK_W-1:0]  link_q, link_d;
  logic [NODE_W-1:0]  node_q, node_d;
  logic [15:0]        neck_q, neck_d;
  logic signed [31:0] dist_t_q, dist_t_d;
  logic [NODE_W-1:0]  tail_q, tail_d;
  logic signed [47:0] prod_q, prod_d;
  logic signed [47:0] cost_q, cost_d;
  logic [19:0]        flow_q, flow_d;

  logic [LINK_W-1:0]  lsa, lsb, k_pair;
  logic signed [16:0] cost_ext;
  logic signed [48:0] prod_full, cost_sum;
  logic [20:0]        flow_sum;
  logic               better;

  assign k_pair    = {k_q[LINK_W-1:1], ~k_q[0]};
  assign cost_ext  = {item_q.edge_cost[15], item_q.edge_cost};
  assign prod_full = dist_t_q * $signed({1'b0, neck_q});
  assign cost_sum  = {cost_q[47], cost_q} + {prod_q[47], prod_q};
  assign flow_sum  = {1'b0, flow_q} + {5'd0, neck_q};
  assign better    = !reached_q[y_q] || (nd_q < node_rd_q.dval);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE) && out_free_i;
  assign res_o       = '{total_cost: cost_q, total_flow: flow_q,
                         feasible: (flow_q >= cfg_i.required_flow)};

  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    ls_vld_d     = ls_vld_q;
    reached_d    = reached_q;
    queued_d     = queued_q;
    head_d       = head_q;
    count_d      = count_q;
    pass_d       = pass_q;
    neck_none_d  = neck_none_q;
    steps_d      = steps_q;
    item_d       = item_q;
    x_d          = x_q;
    dist_x_d     = dist_x_q;
    hop_x_d      = hop_x_q;
    k_d          = k_q;
    y_d          = y_q;
    nd_d         = nd_q;
    link_d       = link_q;
    node_d       = node_q;
    neck_d       = neck_q;
    dist_t_d     = dist_t_q;
    tail_d       = tail_q;
    prod_d       = prod_q;
    cost_d       = cost_q;
    flow_d       = flow_q;
    edge_we = 1'b0; edge_re = 1'b0; edge_wa = '0; edge_ra = '0; edge_wd = '0;
    node_we = 1'b0; node_re = 1'b0; node_wa = '0; node_ra = '0; node_wd = '0;
    ls_we   = 1'b0; ls_re   = 1'b0; ls_wa   = '0; ls_ra   = '0; ls_wd   = '0;
    q_we    = 1'b0; q_re    = 1'b0; q_wa    = '0; q_ra    = '0; q_wd    = '0;
    lsa = ls_vld_q[item_q.from_node] ? ls_rd_q : NO_EDGE;
    // reverse entry of a self loop links to the forward one just written
    lsb = (item_q.to_node == item_q.from_node) ? edge_total_q :
          (ls_vld_q[item_q.to_node] ? ls_rd_q : NO_EDGE);

    unique case (state_q)
      ST_IDLE: begin
        cost_d = '0;
        flow_d = '0;
        if (in_valid_i) begin
          item_d  = in_data_i;
          ls_re   = 1'b1;
          ls_ra   = in_data_i.from_node;
          state_d = ST_LD_F;
        end
      end
      ST_LD_F: begin
        if (edge_total_q <= EDGE_ROOM) begin
          edge_we = 1'b1;
          edge_wa = edge_total_q[EIDX_W-1:0];
          edge_wd = '{head: item_q.to_node, tail: item_q.from_node,
                      res: item_q.capacity, cost: cost_ext, link: lsa};
          ls_we   = 1'b1;
          ls_wa   = item_q.from_node;
          ls_wd   = edge_total_q;
          ls_vld_d[item_q.from_node] = 1'b1;
          ls_re   = 1'b1;
          ls_ra   = item_q.to_node;
          state_d = ST_LD_R;
        end else begin
          state_d = item_q.last_edge ? ST_INIT : ST_IDLE;
        end
      end
      ST_LD_R: begin
        edge_we = 1'b1;
        edge_wa = edge_total_q[EIDX_W-1:0] + 1'b1;
        edge_wd = '{head: item_q.from_node, tail: item_q.to_node,
                    res: 16'd0, cost: -cost_ext, link: lsb};
        ls_we   = 1'b1;
        ls_wa   = item_q.to_node;
        ls_wd   = edge_total_q + 1'b1;
        ls_vld_d[item_q.to_node] = 1'b1;
        edge_total_d = edge_total_q + 2'd2;
        state_d = item_q.last_edge ? ST_INIT : ST_IDLE;
      end
      ST_INIT: begin
        if (cfg_i.source_node == cfg_i.sink_node) begin
          state_d = ST_DONE;
        end else begin
          reached_d = '0;
          queued_d  = '0;
          reached_d[cfg_i.source_node] = 1'b1;
          queued_d[cfg_i.source_node]  = 1'b1;
          q_we    = 1'b1;
          q_wa    = '0;
          q_wd    = cfg_i.source_node;
          head_d  = '0;
          count_d = (NODE_W+1)'(1);
          node_we = 1'b1;
          node_wa = cfg_i.source_node;
          node_wd = '{dval: 32'sd0, arr: NO_EDGE, hop: '0};
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (count_q == '0) begin
          node_d      = cfg_i.sink_node;
          steps_d     = '0;
          neck_none_d = 1'b1;
          neck_d      = '0;
          pass_d      = 1'b0;
          state_d     = reached_q[cfg_i.sink_node] ? ST_WALK_A : ST_DONE;
        end else begin
          q_re    = 1'b1;
          q_ra    = head_q;
          head_d  = head_q + 1'b1;
          count_d = count_q - 1'b1;
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        x_d = q_rd_q;
        queued_d[q_rd_q] = 1'b0;
        ls_re   = 1'b1;
        ls_ra   = q_rd_q;
        node_re = 1'b1;
        node_ra = q_rd_q;
        state_d = ST_LIST;
      end
      ST_LIST: begin
        dist_x_d = node_rd_q.dval;
        hop_x_d  = node_rd_q.hop;
        if (!ls_vld_q[x_q]) begin
          state_d = ST_POP;
        end else begin
          k_d     = ls_rd_q;
          edge_re = 1'b1;
          edge_ra = ls_rd_q[EIDX_W-1:0];
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (edge_rd_q.res == '0) begin
          if (edge_rd_q.link[EIDX_W]) begin
            state_d = ST_POP;
          end else begin
            k_d     = edge_rd_q.link;
            edge_re = 1'b1;
            edge_ra = edge_rd_q.link[EIDX_W-1:0];
          end
        end else begin
          y_d     = edge_rd_q.head;
          nd_d    = dist_x_q + 32'(edge_rd_q.cost);
          link_d  = edge_rd_q.link;
          node_re = 1'b1;
          node_ra = edge_rd_q.head;
          state_d = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (better && hop_x_q == HOP_LAST) begin
          // path too long: a negative cycle, search gives up
          state_d = ST_DONE;
        end else begin
          if (better) begin
            node_we = 1'b1;
            node_wa = y_q;
            node_wd = '{dval: nd_q, arr: k_q, hop: hop_x_q + 1'b1};
            reached_d[y_q] = 1'b1;
            if (y_q == x_q) begin
              dist_x_d = nd_q;
              hop_x_d  = hop_x_q + 1'b1;
            end
            if (!queued_q[y_q] && !count_q[NODE_W]) begin
              q_we    = 1'b1;
              q_wa    = head_q + count_q[NODE_W-1:0];
              q_wd    = y_q;
              queued_d[y_q] = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          if (link_q[EIDX_W]) begin
            state_d = ST_POP;
          end else begin
            k_d     = link_q;
            edge_re = 1'b1;
            edge_ra = link_q[EIDX_W-1:0];
            state_d = ST_EDGE;
          end
        end
      end
      ST_WALK_A: begin
        if (node_q == cfg_i.source_node || steps_q[NODE_W]) begin
          state_d = ST_WALK_E;
        end else begin
          node_re = 1'b1;
          node_ra = node_q;
          state_d = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        if (!pass_q && steps_q == '0) dist_t_d = node_rd_q.dval;
        if (node_rd_q.arr[EIDX_W]) begin
          state_d = ST_WALK_E;
        end else begin
          k_d     = node_rd_q.arr;
          edge_re = 1'b1;
          edge_ra = node_rd_q.arr[EIDX_W-1:0];
          state_d = ST_WALK_C;
        end
      end
      ST_WALK_C: begin
        if (!pass_q) begin
          if (neck_none_q || edge_rd_q.res < neck_q) begin
            neck_d      = edge_rd_q.res;
            neck_none_d = 1'b0;
          end
          node_d  = edge_rd_q.tail;
          steps_d = steps_q + 1'b1;
          state_d = ST_WALK_A;
        end else begin
          edge_we = 1'b1;
          edge_wa = k_q[EIDX_W-1:0];
          edge_wd = edge_rd_q;
          edge_wd.res = edge_rd_q.res - neck_q;
          tail_d  = edge_rd_q.tail;
          edge_re = 1'b1;
          edge_ra = k_pair[EIDX_W-1:0];
          state_d = ST_WALK_D;
        end
      end
      ST_WALK_D: begin
        edge_we = 1'b1;
        edge_wa = k_pair[EIDX_W-1:0];
        edge_wd = edge_rd_q;
        edge_wd.res = edge_rd_q.res + neck_q;
        node_d  = tail_q;
        steps_d = steps_q + 1'b1;
        state_d = ST_WALK_A;
      end
      ST_WALK_E: begin
        if (pass_q) begin
          state_d = ST_ACC1;
        end else if (node_q != cfg_i.source_node || neck_none_q || neck_q == '0) begin
          state_d = ST_DONE;
        end else begin
          pass_d  = 1'b1;
          node_d  = cfg_i.sink_node;
          steps_d = '0;
          state_d = ST_WALK_A;
        end
      end
      ST_ACC1: begin
        prod_d  = prod_full[47:0];
        state_d = ST_ACC2;
      end
      ST_ACC2: begin
        if (cost_sum[48] != cost_sum[47]) begin
          cost_d = cost_sum[48] ? COST_MIN : COST_MAX;
        end else begin
          cost_d = cost_sum[47:0];
        end
        flow_d  = flow_sum[20] ? FLOW_MAX : flow_sum[19:0];
        state_d = ST_INIT;
      end
      ST_DONE: begin
        if (out_free_i) begin
          ls_vld_d     = '0;
          edge_total_d = '0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_total_q <= '0;
      ls_vld_q     <= '0;
      reached_q    <= '0;
      queued_q     <= '0;
      head_q       <= '0;
      count_q      <= '0;
      pass_q       <= 1'b0;
      neck_none_q  <= 1'b1;
      steps_q      <= '0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      ls_vld_q     <= ls_vld_d;
      reached_q    <= reached_d;
      queued_q     <= queued_d;
      head_q       <= head_d;
      count_q      <= count_d;
      pass_q       <= pass_d;
      neck_none_q  <= neck_none_d;
      steps_q      <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    x_q      <= x_d;
    dist_x_q <= dist_x_d;
    hop_x_q  <= hop_x_d;
    k_q      <= k_d;
    y_q      <= y_d;
    nd_q     <= nd_d;
    link_q   <= link_d;
    node_q   <= node_d;
    neck_q   <= neck_d;
    dist_t_q <= dist_t_d;
    tail_q   <= tail_d;
    prod_q   <= prod_d;
    cost_q   <= cost_d;
    flow_q   <= flow_d;
  end

endmodule

>>> design/min_cost_max_flow.sv
// min-cost max-flow solver: edge loading, successive cheapest paths
//
// input channel: one word per directed edge (from, to, capacity, cost, last).
//   each edge is stored in steps: the adjacency head of its tail node is
//   fetched, then the forward and the paired reverse entry are written.
//   edges beyond the 8192-entry store are dropped.
// a word with last_edge set starts the solve. each search is a queue-based
//   shortest path pass over the dequeued nodes and their scanned edges,
//   then two walks back along the path and an addition of cost and flow;
//   total time depends on the graph.
// output channel: one word (total_cost, total_flow, feasible) per graph,
//   held in an output register; while the receiver stalls, the word holds
//   and the solver waits before it starts on the next graph.
// configuration: source, sink and required flow, written while idle.
// reset: empty graph, source 0, sink 1, required flow 0. no clearing pass;
//   the graph is emptied at once after each result.
module min_cost_max_flow import mcmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      out_valid_q;
  out_word_t out_q;
  logic      eng_ready, res_valid, out_free;
  out_word_t res;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !eng_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{source_node: 7'd0, sink_node: 7'd1, required_flow: 20'd0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE:   cfg_q.source_node   <= cfg_data_i[6:0];
        CFG_SINK:     cfg_q.sink_node     <= cfg_data_i[6:0];
        CFG_REQUIRED: cfg_q.required_flow <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  mcmf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (eng_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

endmodule

>>> design/mcmf_checker.sv
// port-level checks of the min-cost max-flow solver
module mcmf_checker import mcmf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_word_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_word_t   out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [19:0] cfg_data_i
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // an accepted edge occupies the loader
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("edge taken while the previous one is being stored");

  // a plain edge is stored, or dropped if the store is full, before the loader is free
  a_edge_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.last_edge |-> ##[2:3] !in_stall_o)
    else $error("edge load did not finish in three cycles");

  // no flow pushed means no cost
  a_zero_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.total_flow == '0 |-> out_data_o.total_cost == '0)
    else $error("cost without flow");

endmodule

bind min_cost_max_flow mcmf_checker u_mcmf_checker (.*);
